// ----- hdl/nthb_pkg.sv -----
// ----------------------------------------------------------------------------
// nthb_pkg
// Shared constants, codes, payload structs and state types of the n-gram
// token hash bucketer.
// ----------------------------------------------------------------------------
package nthb_pkg;

    localparam int NGRAM_LIMIT = 3;
    localparam int MAX_HEADS   = 8;
    localparam int MAX_LAYERS  = 4;
    localparam int MAX_LANES   = 8;
    localparam int VOCAB_DEPTH = 131072;

    localparam int CTX_DEPTH    = NGRAM_LIMIT - 1;
    localparam int MULT_DEPTH   = MAX_LAYERS * NGRAM_LIMIT;
    localparam int BUCKET_DEPTH = MAX_LAYERS * (NGRAM_LIMIT - 1) * MAX_HEADS;

    // fixed field widths
    localparam int OP_W       = 3;
    localparam int LANE_IN_W  = 3;
    localparam int RAW_W      = 32;
    localparam int TOK_W      = 17;
    localparam int CTX_W      = TOK_W + 1;
    localparam int IDX_W      = 17;
    localparam int VAL_W      = 63;
    localparam int HASH_W     = 64;
    localparam int LAYER_OUT_W = 2;
    localparam int COL_W      = 4;
    localparam int STATUS_W   = 2;

    // config register widths
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int NGRAM_CFG_W = 2;
    localparam int HEADS_CFG_W = 4;
    localparam int LAYER_CFG_W = 3;
    localparam int VSZ_W       = 18;

    // derived widths
    localparam int LANE_W    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int NG_W      = $clog2(NGRAM_LIMIT + 1);
    localparam int HEADS_W   = $clog2(MAX_HEADS + 1);
    localparam int LAYERS_W  = $clog2(MAX_LAYERS + 1);
    localparam int POS_W     = $clog2(NGRAM_LIMIT);
    localparam int HEAD_W    = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
    localparam int LAYER_W   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int MULT_AW   = $clog2(MULT_DEPTH);
    localparam int BUCKET_AW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int VOCAB_AW  = $clog2(VOCAB_DEPTH);
    localparam int MUL_CNT_W = $clog2(TOK_W);
    localparam int DIV_CNT_W = $clog2(HASH_W + 1);

    localparam logic [CTX_W-1:0] DEAD_MARK = CTX_W'(1) << TOK_W;

    // op codes
    localparam logic [OP_W-1:0] OP_TOKEN   = 3'd0;
    localparam logic [OP_W-1:0] OP_MULT    = 3'd1;
    localparam logic [OP_W-1:0] OP_PRIME   = 3'd2;
    localparam logic [OP_W-1:0] OP_OFFSET  = 3'd3;
    localparam logic [OP_W-1:0] OP_MAP     = 3'd4;
    localparam logic [OP_W-1:0] OP_ROWS    = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOV   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NGRAM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOCAB  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [LANE_IN_W-1:0] lane;
        logic [RAW_W-1:0]     raw_token;
        logic                 participates;
        logic                 restart;
        logic [IDX_W-1:0]     table_index;
        logic [VAL_W-1:0]     table_value;
    } in_item_t;

    typedef struct packed {
        logic [LAYER_OUT_W-1:0] layer_index;
        logic [COL_W-1:0]       column_index;
        logic [VAL_W-1:0]       row_index;
        logic [STATUS_W-1:0]    status;
        logic                   last;
    } out_item_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] remainder;
    } mod_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_MRD,
        ST_MST,
        ST_MWAIT,
        ST_BRD,
        ST_DST,
        ST_DWAIT,
        ST_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_RUN,
        MOD_FIX,
        MOD_DONE
    } mod_state_t;

endpackage

// ----- hdl/ngram_token_hash_bucketer.sv -----
// ----------------------------------------------------------------------------
// ngram_token_hash_bucketer
// One token is taken at a time: in_ready is high only in the idle state, so a
//   new token waits until the previous one has emitted its last transaction.
// Each head waits on the bit-serial remainder unit and each position on the
//   serial multiplier; output stalls also hold the sequencer.
// Table writes finish in the idle state; an out-of-vocabulary token emits one error transaction.
// Reset: config returns to defaults and lane contexts to token 0; the tables
//   hold garbage until loaded. No clearing pass.
// ----------------------------------------------------------------------------
module ngram_token_hash_bucketer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  nthb_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output nthb_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nthb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nthb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // ---------------- configuration ----------------
    logic [nthb_pkg::NGRAM_CFG_W-1:0] cfg_ngram_reg;
    logic [nthb_pkg::HEADS_CFG_W-1:0] cfg_heads_reg;
    logic [nthb_pkg::LAYER_CFG_W-1:0] cfg_layers_reg;
    logic [nthb_pkg::TOK_W-1:0]       cfg_pad_reg;
    logic [nthb_pkg::VSZ_W-1:0]       cfg_vocab_reg;

    // clamped working values
    logic [nthb_pkg::NG_W-1:0]        n_cl;
    logic [nthb_pkg::HEADS_W-1:0]     h_cl;
    logic [nthb_pkg::LAYERS_W-1:0]    nl_cl;

    // ---------------- sequencer ----------------
    nthb_pkg::seq_state_t             state_reg;
    nthb_pkg::seq_state_t             state_next;
    nthb_pkg::in_item_t               item_reg;
    nthb_pkg::out_item_t              out_reg;
    logic [nthb_pkg::LAYER_W-1:0]     layer_reg;
    logic [nthb_pkg::POS_W-1:0]       pos_reg;
    logic [nthb_pkg::HEAD_W-1:0]      head_reg;
    logic [nthb_pkg::HASH_W-1:0]      rolling_reg;
    logic [nthb_pkg::TOK_W-1:0]       gram_reg [nthb_pkg::NGRAM_LIMIT];
    logic [nthb_pkg::CTX_W-1:0]       ctx_reg [nthb_pkg::MAX_LANES][nthb_pkg::CTX_DEPTH];

    logic                             in_fire;
    logic                             oov;
    logic                             mul_start;
    logic                             mod_start;
    logic                             head_end;
    logic                             pos_end;
    logic                             layer_end;

    // ---------------- tables ----------------
    logic [nthb_pkg::TOK_W-1:0]       map_mem    [nthb_pkg::VOCAB_DEPTH];
    logic [nthb_pkg::VAL_W-1:0]       mult_mem   [nthb_pkg::MULT_DEPTH];
    logic [nthb_pkg::VAL_W-1:0]       prime_mem  [nthb_pkg::BUCKET_DEPTH];
    logic [nthb_pkg::VAL_W-1:0]       offset_mem [nthb_pkg::BUCKET_DEPTH];
    logic [nthb_pkg::VAL_W-1:0]       rows_mem   [nthb_pkg::MAX_LAYERS];
    logic [nthb_pkg::TOK_W-1:0]       map_q;
    logic [nthb_pkg::VAL_W-1:0]       mult_q;
    logic [nthb_pkg::VAL_W-1:0]       prime_q;
    logic [nthb_pkg::VAL_W-1:0]       offset_q;
    logic [nthb_pkg::VAL_W-1:0]       rows_q;
    logic [nthb_pkg::MULT_AW-1:0]     mult_addr;
    logic [nthb_pkg::BUCKET_AW-1:0]   bucket_addr;

    // ---------------- context / gram build ----------------
    logic [nthb_pkg::LANE_W-1:0]      lane_sel;
    logic [nthb_pkg::CTX_W-1:0]       cur_tok;
    logic [nthb_pkg::CTX_W-1:0]       ctx_view [nthb_pkg::CTX_DEPTH];
    logic [nthb_pkg::TOK_W-1:0]       gram_next [nthb_pkg::NGRAM_LIMIT];

    // ---------------- result assembly ----------------
    logic [nthb_pkg::HASH_W-1:0]      row_sum;
    logic [nthb_pkg::COL_W-1:0]       column;

    nthb_pkg::mul_rsp_t               mul_rsp;
    nthb_pkg::mod_rsp_t               mod_rsp;

    function automatic logic item_is_write(input logic [nthb_pkg::OP_W-1:0] code);
        item_is_write = (in_data.op == code);
    endfunction

    assign cfg_ready = 1'b1;

    // config writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ngram_reg  <= nthb_pkg::NGRAM_CFG_W'(3);
            cfg_heads_reg  <= nthb_pkg::HEADS_CFG_W'(8);
            cfg_layers_reg <= nthb_pkg::LAYER_CFG_W'(1);
            cfg_pad_reg    <= '0;
            cfg_vocab_reg  <= nthb_pkg::VSZ_W'(131072);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                nthb_pkg::CFG_NGRAM:  cfg_ngram_reg  <= cfg_data[nthb_pkg::NGRAM_CFG_W-1:0];
                nthb_pkg::CFG_HEADS:  cfg_heads_reg  <= cfg_data[nthb_pkg::HEADS_CFG_W-1:0];
                nthb_pkg::CFG_LAYERS: cfg_layers_reg <= cfg_data[nthb_pkg::LAYER_CFG_W-1:0];
                nthb_pkg::CFG_PAD:    cfg_pad_reg    <= cfg_data[nthb_pkg::TOK_W-1:0];
                nthb_pkg::CFG_VOCAB:  cfg_vocab_reg  <= cfg_data[nthb_pkg::VSZ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp order, heads and layers into their supported ranges
    always_comb
    begin
        if (int'(cfg_ngram_reg) < 2)
            n_cl = nthb_pkg::NG_W'(2);
        else if (int'(cfg_ngram_reg) > nthb_pkg::NGRAM_LIMIT)
            n_cl = nthb_pkg::NG_W'(nthb_pkg::NGRAM_LIMIT);
        else
            n_cl = nthb_pkg::NG_W'(cfg_ngram_reg);

        if (int'(cfg_heads_reg) < 1)
            h_cl = nthb_pkg::HEADS_W'(1);
        else if (int'(cfg_heads_reg) > nthb_pkg::MAX_HEADS)
            h_cl = nthb_pkg::HEADS_W'(nthb_pkg::MAX_HEADS);
        else
            h_cl = nthb_pkg::HEADS_W'(cfg_heads_reg);

        if (int'(cfg_layers_reg) < 1)
            nl_cl = nthb_pkg::LAYERS_W'(1);
        else if (int'(cfg_layers_reg) > nthb_pkg::MAX_LAYERS)
            nl_cl = nthb_pkg::LAYERS_W'(nthb_pkg::MAX_LAYERS);
        else
            nl_cl = nthb_pkg::LAYERS_W'(cfg_layers_reg);
    end

    assign in_fire = in_valid && in_ready;

    // rejected when at or above either the configured size or the map depth
    assign oov = (in_data.raw_token >= nthb_pkg::RAW_W'(cfg_vocab_reg)) ||
                 (in_data.raw_token >= nthb_pkg::RAW_W'(nthb_pkg::VOCAB_DEPTH));

    // table addresses follow the loop counters; read data is registered
    assign mult_addr   = nthb_pkg::MULT_AW'(int'(layer_reg) * int'(n_cl) + int'(pos_reg));
    assign bucket_addr = nthb_pkg::BUCKET_AW'(
        (int'(layer_reg) * (int'(n_cl) - 1) + int'(pos_reg) - 1) * int'(h_cl)
        + int'(head_reg));
    assign column      = nthb_pkg::COL_W'((int'(pos_reg) - 1) * int'(h_cl) + int'(head_reg));

    assign head_end  = (int'(head_reg) == int'(h_cl) - 1);
    assign pos_end   = (int'(pos_reg) == int'(n_cl) - 1);
    assign layer_end = (int'(layer_reg) == int'(nl_cl) - 1);

    // ---------------- table memories ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire && (item_is_write(nthb_pkg::OP_MAP))
            && (int'(in_data.table_index) < nthb_pkg::VOCAB_DEPTH))
        begin
            map_mem[nthb_pkg::VOCAB_AW'(in_data.table_index)] <=
                in_data.table_value[nthb_pkg::TOK_W-1:0];
        end
        if (in_fire)
        begin
            map_q <= map_mem[nthb_pkg::VOCAB_AW'(in_data.raw_token)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && item_is_write(nthb_pkg::OP_MULT)
            && (int'(in_data.table_index) < nthb_pkg::MULT_DEPTH))
        begin
            mult_mem[nthb_pkg::MULT_AW'(in_data.table_index)] <= in_data.table_value;
        end
        mult_q <= mult_mem[mult_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && item_is_write(nthb_pkg::OP_PRIME)
            && (int'(in_data.table_index) < nthb_pkg::BUCKET_DEPTH))
        begin
            prime_mem[nthb_pkg::BUCKET_AW'(in_data.table_index)] <= in_data.table_value;
        end
        prime_q <= prime_mem[bucket_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && item_is_write(nthb_pkg::OP_OFFSET)
            && (int'(in_data.table_index) < nthb_pkg::BUCKET_DEPTH))
        begin
            offset_mem[nthb_pkg::BUCKET_AW'(in_data.table_index)] <= in_data.table_value;
        end
        offset_q <= offset_mem[bucket_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && item_is_write(nthb_pkg::OP_ROWS)
            && (int'(in_data.table_index) < nthb_pkg::MAX_LAYERS))
        begin
            rows_mem[nthb_pkg::LAYER_W'(in_data.table_index)] <= in_data.table_value;
        end
        rows_q <= rows_mem[layer_reg];
    end

    // ---------------- gram build ----------------
    // Restart swaps the lane history for pad before the gram is formed. Walking
    // back from the current token, the first dead mark blocks itself and all
    // older positions, which read as pad.
    assign lane_sel = nthb_pkg::LANE_W'(item_reg.lane);
    assign cur_tok  = item_reg.participates ? {1'b0, map_q} : nthb_pkg::DEAD_MARK;

    always_comb
    begin
        logic blocked;
        logic [nthb_pkg::CTX_W-1:0] src;
        blocked = 1'b0;
        for (int c = 0; c < nthb_pkg::CTX_DEPTH; c++)
        begin
            ctx_view[c] = item_reg.restart ? {1'b0, cfg_pad_reg} : ctx_reg[lane_sel][c];
        end
        for (int s = 0; s < nthb_pkg::NGRAM_LIMIT; s++)
        begin
            src = (s == 0) ? cur_tok : ctx_view[(s == 0) ? 0 : s - 1];
            if (src[nthb_pkg::TOK_W])
            begin
                blocked = 1'b1;
            end
            gram_next[s] = blocked ? cfg_pad_reg : src[nthb_pkg::TOK_W-1:0];
        end
    end

    // remainder plus offset; compared at full 64 bits against the row count
    assign row_sum = nthb_pkg::HASH_W'(mod_rsp.remainder) + nthb_pkg::HASH_W'(offset_q);

    // ---------------- sequencer next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nthb_pkg::ST_IDLE:
            begin
                if (in_valid && (in_data.op == nthb_pkg::OP_TOKEN))
                begin
                    state_next = oov ? nthb_pkg::ST_EMIT : nthb_pkg::ST_MAP;
                end
            end
            nthb_pkg::ST_MAP:   state_next = nthb_pkg::ST_MRD;
            nthb_pkg::ST_MRD:   state_next = nthb_pkg::ST_MST;
            nthb_pkg::ST_MST:   state_next = nthb_pkg::ST_MWAIT;
            nthb_pkg::ST_MWAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (pos_reg == '0) ? nthb_pkg::ST_MRD : nthb_pkg::ST_BRD;
                end
            end
            nthb_pkg::ST_BRD:   state_next = nthb_pkg::ST_DST;
            nthb_pkg::ST_DST:   state_next = nthb_pkg::ST_DWAIT;
            nthb_pkg::ST_DWAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = nthb_pkg::ST_EMIT;
                end
            end
            nthb_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (out_reg.last)
                        state_next = nthb_pkg::ST_IDLE;
                    else if (!head_end)
                        state_next = nthb_pkg::ST_BRD;
                    else
                        state_next = nthb_pkg::ST_MRD;
                end
            end
            default:            state_next = nthb_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        in_ready  = (state_reg == nthb_pkg::ST_IDLE);
        out_valid = (state_reg == nthb_pkg::ST_EMIT);
        mul_start = (state_reg == nthb_pkg::ST_MST);
        mod_start = (state_reg == nthb_pkg::ST_DST);
        out_data  = out_reg;
    end

    // control state and lane history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nthb_pkg::ST_IDLE;
            for (int l = 0; l < nthb_pkg::MAX_LANES; l++)
            begin
                for (int c = 0; c < nthb_pkg::CTX_DEPTH; c++)
                begin
                    ctx_reg[l][c] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            // history shifts in the same cycle as the gram is captured
            if (state_reg == nthb_pkg::ST_MAP)
            begin
                for (int c = nthb_pkg::CTX_DEPTH - 1; c > 0; c--)
                begin
                    ctx_reg[lane_sel][c] <= ctx_view[c - 1];
                end
                ctx_reg[lane_sel][0] <= cur_tok;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            nthb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_reg <= in_data;
                    // rejected token: single error transaction, state untouched
                    out_reg.layer_index  <= '0;
                    out_reg.column_index <= '0;
                    out_reg.row_index    <= '0;
                    out_reg.status       <= nthb_pkg::STATUS_OOV;
                    out_reg.last         <= 1'b1;
                end
            end
            nthb_pkg::ST_MAP:
            begin
                for (int s = 0; s < nthb_pkg::NGRAM_LIMIT; s++)
                begin
                    gram_reg[s] <= gram_next[s];
                end
                layer_reg   <= '0;
                pos_reg     <= '0;
                head_reg    <= '0;
                rolling_reg <= '0;
            end
            nthb_pkg::ST_MWAIT:
            begin
                if (mul_rsp.done)
                begin
                    rolling_reg <= rolling_reg ^ mul_rsp.product;
                    if (pos_reg == '0)
                    begin
                        pos_reg <= nthb_pkg::POS_W'(1);
                    end
                end
            end
            nthb_pkg::ST_DWAIT:
            begin
                if (mod_rsp.done)
                begin
                    out_reg.layer_index  <= nthb_pkg::LAYER_OUT_W'(layer_reg);
                    out_reg.column_index <= column;
                    out_reg.row_index    <= row_sum[nthb_pkg::VAL_W-1:0];
                    out_reg.status       <= (row_sum >= nthb_pkg::HASH_W'(rows_q)) ?
                                            nthb_pkg::STATUS_RANGE : nthb_pkg::STATUS_OK;
                    out_reg.last         <= head_end && pos_end && layer_end;
                end
            end
            nthb_pkg::ST_EMIT:
            begin
                if (out_ready && !out_reg.last)
                begin
                    if (!head_end)
                    begin
                        head_reg <= head_reg + 1'b1;
                    end
                    else if (!pos_end)
                    begin
                        head_reg <= '0;
                        pos_reg  <= pos_reg + 1'b1;
                    end
                    else
                    begin
                        head_reg    <= '0;
                        pos_reg     <= '0;
                        layer_reg   <= layer_reg + 1'b1;
                        rolling_reg <= '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- arithmetic units ----------------
    nthb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .token (gram_reg[pos_reg]),
        .mcand (nthb_pkg::HASH_W'(mult_q)),
        .rsp   (mul_rsp)
    );

    nthb_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (rolling_reg),
        .divisor  (prime_q),
        .rsp      (mod_rsp)
    );

    a_oov_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == nthb_pkg::STATUS_OOV)) |-> out_data.last)
        else $error("error transaction without last");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == nthb_pkg::ST_MWAIT))
        else $error("product arrived outside wait state");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped or changed while stalled");

endmodule

// ----- hdl/nthb_mul.sv -----
// ----------------------------------------------------------------------------
// nthb_mul
// Bit-serial multiplier: one token bit per cycle, product wraps at 64 bits.
// ----------------------------------------------------------------------------
module nthb_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nthb_pkg::TOK_W-1:0]    token,
    input  logic [nthb_pkg::HASH_W-1:0]   mcand,
    output nthb_pkg::mul_rsp_t            rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [nthb_pkg::MUL_CNT_W-1:0]   cnt_reg;
    logic [nthb_pkg::TOK_W-1:0]       tok_reg;
    logic [nthb_pkg::HASH_W-1:0]      mc_reg;
    logic [nthb_pkg::HASH_W-1:0]      acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nthb_pkg::MUL_CNT_W'(nthb_pkg::TOK_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tok_reg <= token;
            mc_reg  <= mcand;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (tok_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            tok_reg <= tok_reg >> 1;
            mc_reg  <= mc_reg << 1;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ----- hdl/nthb_mod.sv -----
// ----------------------------------------------------------------------------
// nthb_mod
// Serial signed remainder: restoring division, one dividend bit per cycle,
// result folded to the non-negative remainder.
// ----------------------------------------------------------------------------
module nthb_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nthb_pkg::HASH_W-1:0]   dividend,
    input  logic [nthb_pkg::VAL_W-1:0]    divisor,
    output nthb_pkg::mod_rsp_t            rsp
);

    nthb_pkg::mod_state_t             state_reg;
    nthb_pkg::mod_state_t             state_next;
    logic [nthb_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                             neg_reg;
    logic [nthb_pkg::HASH_W-1:0]      m_reg;
    logic [nthb_pkg::VAL_W-1:0]       p_reg;
    logic [nthb_pkg::VAL_W-1:0]       r_reg;
    logic [nthb_pkg::HASH_W-1:0]      trial;
    logic [nthb_pkg::HASH_W-1:0]      diff;

    assign trial = {r_reg, m_reg[nthb_pkg::HASH_W-1]};
    assign diff  = trial - nthb_pkg::HASH_W'(p_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nthb_pkg::MOD_IDLE:
            begin
                if (start)
                begin
                    state_next = nthb_pkg::MOD_RUN;
                end
            end
            nthb_pkg::MOD_RUN:
            begin
                if (cnt_reg == nthb_pkg::DIV_CNT_W'(nthb_pkg::HASH_W - 1))
                begin
                    state_next = nthb_pkg::MOD_FIX;
                end
            end
            nthb_pkg::MOD_FIX:  state_next = nthb_pkg::MOD_DONE;
            nthb_pkg::MOD_DONE: state_next = nthb_pkg::MOD_IDLE;
            default:            state_next = nthb_pkg::MOD_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done      = (state_reg == nthb_pkg::MOD_DONE);
        rsp.remainder = r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nthb_pkg::MOD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == nthb_pkg::MOD_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            nthb_pkg::MOD_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= dividend[nthb_pkg::HASH_W-1];
                    m_reg   <= dividend[nthb_pkg::HASH_W-1] ? (~dividend + 1'b1) : dividend;
                    p_reg   <= divisor;
                    r_reg   <= '0;
                end
            end
            nthb_pkg::MOD_RUN:
            begin
                m_reg <= m_reg << 1;
                if (trial >= nthb_pkg::HASH_W'(p_reg))
                begin
                    r_reg <= diff[nthb_pkg::VAL_W-1:0];
                end
                else
                begin
                    r_reg <= trial[nthb_pkg::VAL_W-1:0];
                end
            end
            nthb_pkg::MOD_FIX:
            begin
                // zero divisor gives zero; negative input folds to p - r
                if (p_reg == '0)
                begin
                    r_reg <= '0;
                end
                else if (neg_reg && (r_reg != '0))
                begin
                    r_reg <= p_reg - r_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == nthb_pkg::MOD_IDLE))
        else $error("remainder unit started while busy");

    a_rem_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> ((p_reg == '0) || (r_reg < p_reg)))
        else $error("remainder not below divisor");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("remainder done held");

endmodule
